// ----- sv/tsce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor sine/cosine/exponential package
// Shared widths, opcodes, argument limits and sequencer states.
// ----------------------------------------------------------------------------
package tsce_pkg;

   localparam int OPCODE_W     = 2;
   localparam int ARG_W        = 32;
   localparam int RESULT_W     = 48;
   localparam int TERM_COUNT_W = 7;
   localparam int AX_W         = 28;
   localparam int MAG_W        = 56;
   localparam int SUM_W        = 64;
   localparam int PROD_W       = 2 * AX_W;
   localparam int QUO_W        = 64;
   localparam int DIGITS_PER_CYCLE = 8;
   localparam int DIV_CYCLES   = QUO_W / DIGITS_PER_CYCLE;
   localparam int DCNT_W       = $clog2(DIV_CYCLES);
   localparam int SHIFT_OUT    = 16;
   localparam int MUL_SHIFT    = 24;

   localparam logic [OPCODE_W-1:0] OP_SIN     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_COS     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_EXP     = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_INVALID = 2'd3;

   localparam logic [ARG_W-1:0] TRIG_LIMIT    = 32'h0800_0000;
   localparam logic [ARG_W-1:0] EXP_POS_LIMIT = 32'h0A80_0000;
   localparam logic [ARG_W-1:0] EXP_NEG_LIMIT = 32'h0800_0000;

   localparam logic [MAG_W-1:0] ONE_Q40 = 56'h00_0100_0000_0000;

   localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 7'd48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

// ----- sv/tsce_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor unit request channel
// Valid/ready channel carrying the opcode and the Q8.24 argument.
// ----------------------------------------------------------------------------
interface tsce_req_if;
   logic                                valid;
   logic                                ready;
   logic [tsce_pkg::OPCODE_W-1:0]       opcode;
   logic signed [tsce_pkg::ARG_W-1:0]   arg_x;

   modport source (output valid, output opcode, output arg_x, input ready);
   modport sink   (input valid, input opcode, input arg_x, output ready);
endinterface

// ----- sv/tsce_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor unit response channel
// Valid/ready channel carrying the Q24.24 result and the range flag.
// ----------------------------------------------------------------------------
interface tsce_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tsce_pkg::RESULT_W-1:0] result_value;
   logic                                 out_of_range;

   modport source (output valid, output result_value, output out_of_range, input ready);
   modport sink   (input valid, input result_value, input out_of_range, output ready);
endinterface

// ----- sv/taylor_sin_cos_exp_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor series sine/cosine/exponential unit
// Sums N terms with one shared 28x28 multiplier and an 8-digit-per-cycle divider.
// ----------------------------------------------------------------------------
// Sequence: each term is added to the sum; before each further term the magnitude
//   is scaled by one factor for exp and two for sin/cos, each factor being a
//   low and a high multiply step and then the divide steps; invalid opcode goes straight to finish.
// Throughput: one item at a time; the next request is taken in the cycle
//   after the response register loads. Reset is synchronous: sequencer idle,
//   response invalid, term_count back to 48.
module taylor_sin_cos_exp_unit #(
   parameter int MAX_TERMS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tsce_req_if.sink                              req_if,
   tsce_rsp_if.source                            rsp_if,
   input  logic                                  csr_write_en,
   input  logic [tsce_pkg::TERM_COUNT_W-1:0]     csr_write_data
);

   localparam int CNT_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int DIV_W = CNT_W + 2;
   localparam logic [tsce_pkg::TERM_COUNT_W-1:0] MAX_TC =
      tsce_pkg::TERM_COUNT_W'(MAX_TERMS);
   localparam logic [CNT_W-1:0] MAX_LAST = CNT_W'(MAX_TERMS - 1);

   tsce_pkg::state_type state_ff, state_in;

   logic [tsce_pkg::TERM_COUNT_W-1:0] term_count_ff;
   logic [tsce_pkg::OPCODE_W-1:0]     op_ff, op_in;
   logic                              neg_ff, neg_in;
   logic [tsce_pkg::AX_W-1:0]         ax_ff, ax_in;
   logic                              oor_ff, oor_in;
   logic [tsce_pkg::MAG_W-1:0]        m_ff, m_in;
   logic [tsce_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]                  idx_ff, idx_in;
   logic [CNT_W-1:0]                  last_ff, last_in;
   logic                              phase_ff, phase_in;
   logic [tsce_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [tsce_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [DIV_W-1:0]                  rem_ff, rem_in;
   logic [tsce_pkg::DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tsce_pkg::RESULT_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                              rsp_oor_ff, rsp_oor_in;

   logic [tsce_pkg::ARG_W-1:0]        raw_u;
   logic [tsce_pkg::ARG_W-1:0]        ax_abs;
   logic [tsce_pkg::ARG_W-1:0]        ax_lim;
   logic [tsce_pkg::ARG_W-1:0]        ax_clamp;
   logic                              ax_over;
   logic [CNT_W-1:0]                  last_calc;

   logic [tsce_pkg::AX_W-1:0]         mul_a;
   logic [tsce_pkg::PROD_W-1:0]       mul_p;
   logic [tsce_pkg::PROD_W+tsce_pkg::AX_W-1:0] mul_full;
   logic [DIV_W-1:0]                  divisor;
   logic [DIV_W-1:0]                  idx_ext;
   logic [tsce_pkg::QUO_W-1:0]        div_q;
   logic [DIV_W-1:0]                  div_r;
   logic                              term_neg;
   logic                              rsp_load;

   // argument magnitude, clamp and term count for a new transfer
   always_comb begin
      raw_u  = $unsigned(req_if.arg_x);
      ax_abs = raw_u[tsce_pkg::ARG_W-1] ? (~raw_u + 1'b1) : raw_u;
      if (req_if.opcode == tsce_pkg::OP_EXP) begin
         ax_lim = raw_u[tsce_pkg::ARG_W-1] ? tsce_pkg::EXP_NEG_LIMIT
                                           : tsce_pkg::EXP_POS_LIMIT;
      end else begin
         ax_lim = tsce_pkg::TRIG_LIMIT;
      end
      ax_over  = ax_abs > ax_lim;
      ax_clamp = ax_over ? ax_lim : ax_abs;
      if (term_count_ff == '0) begin
         last_calc = '0;
      end else if (term_count_ff > MAX_TC) begin
         last_calc = MAX_LAST;
      end else begin
         last_calc = CNT_W'(term_count_ff - 1'b1);
      end
   end

   // shared multiplier: low then high half of the magnitude
   assign mul_a = (state_ff == tsce_pkg::ST_MUL_HI) ? m_ff[tsce_pkg::MAG_W-1:tsce_pkg::AX_W]
                                                    : m_ff[tsce_pkg::AX_W-1:0];
   assign mul_p = mul_a * ax_ff;
   assign mul_full = {{tsce_pkg::AX_W{1'b0}}, prod_ff} + {mul_p, {tsce_pkg::AX_W{1'b0}}};

   // factorial factor for the current step
   always_comb begin
      idx_ext = DIV_W'(idx_ff);
      case (op_ff)
         tsce_pkg::OP_SIN: divisor = (idx_ext << 1) + (phase_ff ? DIV_W'(3) : DIV_W'(2));
         tsce_pkg::OP_COS: divisor = (idx_ext << 1) + (phase_ff ? DIV_W'(2) : DIV_W'(1));
         default:          divisor = idx_ext + DIV_W'(1);
      endcase
   end

   // restoring division, eight quotient digits per cycle
   always_comb begin
      logic [DIV_W:0] rt;
      div_q = quo_ff;
      div_r = rem_ff;
      for (int k = 0; k < tsce_pkg::DIGITS_PER_CYCLE; k++) begin
         rt    = {div_r, div_q[tsce_pkg::QUO_W-1]};
         div_q = {div_q[tsce_pkg::QUO_W-2:0], 1'b0};
         if (rt >= {1'b0, divisor}) begin
            rt       = rt - {1'b0, divisor};
            div_q[0] = 1'b1;
         end
         div_r = rt[DIV_W-1:0];
      end
   end

   always_comb begin
      case (op_ff)
         tsce_pkg::OP_SIN: term_neg = neg_ff ^ idx_ff[0];
         tsce_pkg::OP_COS: term_neg = idx_ff[0];
         default:          term_neg = neg_ff & idx_ff[0];
      endcase
   end

   assign rsp_load = (state_ff == tsce_pkg::ST_FIN) && (!rsp_valid_ff || rsp_if.ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      ax_in        = ax_ff;
      oor_in       = oor_ff;
      m_in         = m_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      case (state_ff)
         tsce_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.opcode;
               neg_in   = raw_u[tsce_pkg::ARG_W-1];
               ax_in    = ax_clamp[tsce_pkg::AX_W-1:0];
               oor_in   = ax_over || (req_if.opcode == tsce_pkg::OP_INVALID);
               sum_in   = '0;
               idx_in   = '0;
               last_in  = last_calc;
               phase_in = 1'b0;
               if (req_if.opcode == tsce_pkg::OP_SIN) begin
                  m_in = {{(tsce_pkg::MAG_W - tsce_pkg::AX_W - 16){1'b0}},
                          ax_clamp[tsce_pkg::AX_W-1:0], 16'h0000};
               end else begin
                  m_in = tsce_pkg::ONE_Q40;
               end
               state_in = (req_if.opcode == tsce_pkg::OP_INVALID) ? tsce_pkg::ST_FIN
                                                                  : tsce_pkg::ST_ACC;
            end
         end
         tsce_pkg::ST_ACC: begin
            if (term_neg) begin
               sum_in = sum_ff - {{(tsce_pkg::SUM_W - tsce_pkg::MAG_W){1'b0}}, m_ff};
            end else begin
               sum_in = sum_ff + {{(tsce_pkg::SUM_W - tsce_pkg::MAG_W){1'b0}}, m_ff};
            end
            state_in = (idx_ff == last_ff) ? tsce_pkg::ST_FIN : tsce_pkg::ST_MUL_LO;
         end
         tsce_pkg::ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = tsce_pkg::ST_MUL_HI;
         end
         tsce_pkg::ST_MUL_HI: begin
            quo_in   = tsce_pkg::QUO_W'(mul_full >> tsce_pkg::MUL_SHIFT);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = tsce_pkg::ST_DIV;
         end
         tsce_pkg::ST_DIV: begin
            quo_in  = div_q;
            rem_in  = div_r;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == tsce_pkg::DCNT_W'(tsce_pkg::DIV_CYCLES - 1)) begin
               m_in = div_q[tsce_pkg::MAG_W-1:0];
               if ((op_ff != tsce_pkg::OP_EXP) && !phase_ff) begin
                  phase_in = 1'b1;
                  state_in = tsce_pkg::ST_MUL_LO;
               end else begin
                  phase_in = 1'b0;
                  idx_in   = idx_ff + 1'b1;
                  state_in = tsce_pkg::ST_ACC;
               end
            end
         end
         tsce_pkg::ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sum_ff[tsce_pkg::SUM_W-1:tsce_pkg::SHIFT_OUT];
               rsp_oor_in   = oor_ff;
               state_in     = tsce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsce_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsce_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         term_count_ff <= tsce_pkg::TERM_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            term_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      neg_ff       <= neg_in;
      ax_ff        <= ax_in;
      oor_ff       <= oor_in;
      m_ff         <= m_in;
      sum_ff       <= sum_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      phase_ff     <= phase_in;
      prod_ff      <= prod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign req_if.ready        = (state_ff == tsce_pkg::ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = $signed(rsp_value_ff);
   assign rsp_if.out_of_range = rsp_oor_ff;

endmodule

// ----- sv/tsce_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Taylor unit port checker
// Handshake and sequencing checks on the top-level ports.
// ----------------------------------------------------------------------------
module tsce_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tsce_pkg::RESULT_W-1:0]     rsp_result_value,
   input logic                              rsp_out_of_range
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without an item in flight");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset left the unit busy");

endmodule

bind taylor_sin_cos_exp_unit tsce_checker u_tsce_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.result_value),
   .rsp_out_of_range (rsp_if.out_of_range)
);
